### design/pbpm_pkg.sv
`default_nettype none

package pbpm_pkg;

  localparam int ECHO_W   = 16;
  localparam int DIST_W   = 12;
  localparam int THR_W    = 9;
  localparam int FREQ_W   = 15;
  localparam int PERIOD_W = 20;
  localparam int DUTY_W   = 16;
  localparam int ZONE_W   = 2;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 16;

  localparam int DVD_W  = 20;
  localparam int DVSR_W = 25;
  localparam int NUM2_W = 29;
  localparam int CNT_W  = 5;
  localparam int PROD_W = 32;

  // floor(x / 58) as (x * 36158) >> 21, exact for any 16-bit x
  localparam logic [ECHO_W-1:0]   DIST_RECIP    = 16'd36158;
  localparam int                  DIST_SHIFT    = 21;
  localparam logic [16:0]         DUTY_R_MULT   = 17'd95;
  localparam logic [16:0]         DUTY_A_MULT   = 17'd90;
  localparam logic [DUTY_W-1:0]   DUTY_DEN_MULT = DUTY_W'(100);
  localparam logic [NUM2_W-1:0]   PERIOD_SCALE  = NUM2_W'(1000000);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX    = PERIOD_W'(1000000);

  localparam logic [CNT_W-1:0] DUTY_ITER = CNT_W'(16);
  localparam logic [CNT_W-1:0] PER_ITER  = CNT_W'(20);

  localparam logic [THR_W-1:0]  HIGH_RESET = THR_W'(5);
  localparam logic [THR_W-1:0]  MED_RESET  = THR_W'(15);
  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(350);

  localparam logic [ZONE_W-1:0] ZONE_NEAR = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_BAND = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_FAR  = 2'd2;

  localparam logic [CIDX_W-1:0] REG_HIGH_RISK  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MED_RISK   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BASE_FREQ  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ECHO_CORR  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BUZZ_EN    = 3'd4;

  typedef logic [3:0] step_t;

  localparam step_t S_DLD   = 4'd0;
  localparam step_t S_DIST  = 4'd1;
  localparam step_t S_CLS   = 4'd2;
  localparam step_t S_NUM   = 4'd3;
  localparam step_t S_DRUN2 = 4'd4;
  localparam step_t S_DUTY  = 4'd5;
  localparam step_t S_MUL   = 4'd6;
  localparam step_t S_PLD   = 4'd7;
  localparam step_t S_DRUN3 = 4'd8;
  localparam step_t S_PER   = 4'd9;
  localparam step_t S_SAT   = 4'd10;
  localparam step_t S_END   = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIST_LOAD,
    OP_DIV_STEP,
    OP_DIST,
    OP_CLASSIFY,
    OP_DUTY_LOAD,
    OP_DUTY,
    OP_MUL,
    OP_PER_LOAD,
    OP_PERIOD,
    OP_SAT,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_MORE,
    C_NO_LOAD,
    C_DEN_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: S_DLD};
    case (step)
      S_DLD:   w = '{op: OP_DIST_LOAD, cond: C_NEVER,    target: S_DLD};
      S_DIST:  w = '{op: OP_DIST,      cond: C_NEVER,    target: S_DLD};
      S_CLS:   w = '{op: OP_CLASSIFY,  cond: C_NO_LOAD,  target: S_END};
      S_NUM:   w = '{op: OP_DUTY_LOAD, cond: C_NEVER,    target: S_DLD};
      S_DRUN2: w = '{op: OP_DIV_STEP,  cond: C_MORE,     target: S_DRUN2};
      S_DUTY:  w = '{op: OP_DUTY,      cond: C_NEVER,    target: S_DLD};
      S_MUL:   w = '{op: OP_MUL,       cond: C_NEVER,    target: S_DLD};
      S_PLD:   w = '{op: OP_PER_LOAD,  cond: C_DEN_ZERO, target: S_SAT};
      S_DRUN3: w = '{op: OP_DIV_STEP,  cond: C_MORE,     target: S_DRUN3};
      S_PER:   w = '{op: OP_PERIOD,    cond: C_ALWAYS,   target: S_END};
      S_SAT:   w = '{op: OP_SAT,       cond: C_NEVER,    target: S_DLD};
      S_END:   w = '{op: OP_DONE,      cond: C_OUT_BUSY, target: S_END};
      default: w = '{op: OP_DONE,      cond: C_NEVER,    target: S_DLD};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/proximity_buzzer_pwm_mapper_core.sv
// Proximity buzzer PWM mapper.
// Echo channel: echo_valid/echo_stall carry one echo_us item. The block stalls
// the channel while an item is in progress and accepts one item at a time.
// Result channel: result_valid/result_stall carry one result item per echo.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high. The user writes registers only while the block is idle (not enforced).
// A microcode sequencer drives a reciprocal multiply for the distance, one
// shared restoring divider (one quotient bit per cycle) and a small multiply
// stage. The divider forms the 16-bit duty quotient, then the 20-bit period
// quotient. Items outside the band or without a PWM load skip both; a zero
// base frequency skips the period division and saturates the period. The
// next item can be accepted in the cycle after a result issues.
// A finished result waits in the output register while result_stall is high;
// a new item may run meanwhile and then holds in its last step until the
// output register is free.
// Reset (rst, synchronous) restores register defaults, clears the stored band
// distance and drops result_valid.
`default_nettype none

module proximity_buzzer_pwm_mapper_core
  import pbpm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       echo_valid,
  output logic                            echo_stall,
  input  wire logic [ECHO_W-1:0]          echo_us,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic signed [DIST_W-1:0]        distance_cm,
  output logic [ZONE_W-1:0]               zone,
  output logic                            suspend_buzzer,
  output logic                            resume_buzzer,
  output logic                            load_pwm,
  output logic [PERIOD_W-1:0]             pwm_period,
  output logic [DUTY_W-1:0]               duty_q16,
  output logic                            config_error,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CIDX_W-1:0]          cfg_index,
  input  wire logic [CDATA_W-1:0]         cfg_data
);

  logic [THR_W-1:0]  high_risk_cm;
  logic [THR_W-1:0]  medium_risk_cm;
  logic [FREQ_W-1:0] base_freq_hz;
  logic [ECHO_W-1:0] echo_correction_us;
  logic              buzzer_enable;
  logic signed [DIST_W-1:0] last_band_distance;

  logic              busy;
  step_t             step;
  ctrl_word_t        cw;
  logic              jump;
  logic              retire;

  logic [ECHO_W-1:0] echo;
  logic              neg;
  logic [PROD_W-1:0] prod;
  logic [DVD_W-1:0]  dvd;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic [CNT_W-1:0]  cnt;
  logic [NUM2_W-1:0] num2;
  logic [DVSR_W-1:0] den;

  logic signed [DIST_W-1:0] dist_val;
  logic [ZONE_W-1:0]        w_zone;
  logic                     w_susp;
  logic                     w_res;
  logic                     w_load;
  logic                     w_cerr;
  logic [PERIOD_W-1:0]      w_period;
  logic [DUTY_W-1:0]        w_duty;

  logic              accept;
  logic              out_busy;
  logic [ECHO_W:0]   diff;
  logic [ECHO_W:0]   ndiff;
  logic [ECHO_W-1:0] mag;
  logic [DVSR_W+1:0] trial;
  logic [DIST_W-1:0] q_dist;
  logic signed [DIST_W-1:0] hi_s;
  logic signed [DIST_W-1:0] md_s;
  logic              in_band;
  logic              beyond;
  logic              cerr;
  logic              changed;
  logic              no_load;
  logic [THR_W-1:0]  r_w;
  logic [THR_W-1:0]  a_w;
  logic [THR_W:0]    twor_a;
  logic [16:0]       n95;
  logic [16:0]       n90;
  logic [16:0]       num_duty;
  logic [DUTY_W-1:0] den_duty;

  assign accept     = echo_valid && !echo_stall;
  assign echo_stall = busy;
  assign cfg_ready  = 1'b1;
  assign out_busy   = result_valid && result_stall;

  assign cw     = ucode(step);
  assign retire = busy && cw.op == OP_DONE && !out_busy;

  assign diff  = {1'b0, echo} - {1'b0, echo_correction_us};
  assign ndiff = ~diff + 17'd1;
  assign mag   = diff[ECHO_W] ? ndiff[ECHO_W-1:0] : diff[ECHO_W-1:0];

  assign trial = {1'b0, rem, dvd[DVD_W-1]} - {2'b00, dvsr};

  assign q_dist = DIST_W'(prod[PROD_W-1:DIST_SHIFT]);

  assign hi_s    = $signed({3'b000, high_risk_cm});
  assign md_s    = $signed({3'b000, medium_risk_cm});
  assign in_band = (dist_val >= hi_s) && (dist_val <= md_s);
  assign beyond  = dist_val > md_s;
  assign cerr    = high_risk_cm == medium_risk_cm;
  assign changed = dist_val != last_band_distance;
  assign no_load = !(in_band && buzzer_enable && !cerr && changed);

  assign r_w      = medium_risk_cm - high_risk_cm;
  assign a_w      = dist_val[THR_W-1:0] - high_risk_cm;
  assign twor_a   = {r_w, 1'b0} - {1'b0, a_w};
  assign n95      = 17'(r_w) * DUTY_R_MULT;
  assign n90      = 17'(a_w) * DUTY_A_MULT;
  assign num_duty = n95 - n90;
  assign den_duty = DUTY_W'(r_w) * DUTY_DEN_MULT;

  always_comb begin
    case (cw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_MORE:     jump = cnt != CNT_W'(1);
      C_NO_LOAD:  jump = no_load;
      C_DEN_ZERO: jump = num2 == '0 ? 1'b0 : den == '0;
      C_OUT_BUSY: jump = out_busy;
      default:    jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_risk_cm       <= HIGH_RESET;
      medium_risk_cm     <= MED_RESET;
      base_freq_hz       <= FREQ_RESET;
      echo_correction_us <= '0;
      buzzer_enable      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIGH_RISK: high_risk_cm       <= cfg_data[THR_W-1:0];
        REG_MED_RISK:  medium_risk_cm     <= cfg_data[THR_W-1:0];
        REG_BASE_FREQ: base_freq_hz       <= cfg_data[FREQ_W-1:0];
        REG_ECHO_CORR: echo_correction_us <= cfg_data;
        REG_BUZZ_EN:   buzzer_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy               <= 1'b0;
      step               <= S_DLD;
      result_valid       <= 1'b0;
      last_band_distance <= '0;
    end else begin
      if (retire) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        step <= S_DLD;
      end else if (busy) begin
        if (retire) begin
          busy <= 1'b0;
          step <= S_DLD;
        end else begin
          step <= jump ? cw.target : step + 4'd1;
        end
        if (cw.op == OP_CLASSIFY && in_band && buzzer_enable) begin
          last_band_distance <= dist_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      echo     <= echo_us;
      w_period <= '0;
      w_duty   <= '0;
      w_load   <= 1'b0;
    end else if (busy) begin
      case (cw.op)
        OP_DIST_LOAD: begin
          neg  <= diff[ECHO_W];
          prod <= PROD_W'(mag) * PROD_W'(DIST_RECIP);
        end
        OP_DIV_STEP: begin
          if (!trial[DVSR_W+1]) begin
            rem <= trial[DVSR_W-1:0];
          end else begin
            rem <= {rem[DVSR_W-2:0], dvd[DVD_W-1]};
          end
          dvd <= {dvd[DVD_W-2:0], !trial[DVSR_W+1]};
          cnt <= cnt - CNT_W'(1);
        end
        OP_DIST: begin
          dist_val <= neg ? $signed(~q_dist + 12'd1) : $signed(q_dist);
        end
        OP_CLASSIFY: begin
          w_cerr <= cerr;
          w_res  <= in_band && buzzer_enable;
          w_susp <= !in_band && beyond;
          w_load <= !no_load;
          if (in_band) begin
            w_zone <= ZONE_BAND;
          end else if (beyond) begin
            w_zone <= ZONE_FAR;
          end else begin
            w_zone <= ZONE_NEAR;
          end
        end
        OP_DUTY_LOAD: begin
          rem  <= DVSR_W'(num_duty[DUTY_W-1:0]);
          dvd  <= '0;
          dvsr <= DVSR_W'(den_duty);
          cnt  <= DUTY_ITER;
        end
        OP_DUTY: begin
          w_duty <= dvd[DUTY_W-1:0];
        end
        OP_MUL: begin
          num2 <= NUM2_W'(r_w) * PERIOD_SCALE;
          den  <= DVSR_W'(base_freq_hz) * DVSR_W'(twor_a);
        end
        OP_PER_LOAD: begin
          rem  <= DVSR_W'(num2[NUM2_W-1:DVD_W]);
          dvd  <= num2[DVD_W-1:0];
          dvsr <= den;
          cnt  <= PER_ITER;
        end
        OP_PERIOD: begin
          w_period <= dvd;
        end
        OP_SAT: begin
          w_period <= PERIOD_MAX;
        end
        OP_DONE: begin
          if (!out_busy) begin
            distance_cm    <= dist_val;
            zone           <= w_zone;
            suspend_buzzer <= w_susp;
            resume_buzzer  <= w_res;
            load_pwm       <= w_load;
            pwm_period     <= w_period;
            duty_q16       <= w_duty;
            config_error   <= w_cerr;
          end
        end
        default: ;
      endcase
    end
  end

  a_load_in_band: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!load_pwm || (resume_buzzer && zone == ZONE_BAND && !config_error)))
    else $error("PWM load outside an enabled band item");

  a_suspend_far: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (suspend_buzzer == (zone == ZONE_FAR)))
    else $error("suspend does not match zone");

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && step == S_DLD))
    else $error("sequencer did not start at first step");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == S_DLD)
    else $error("step counter moved while idle");

endmodule

`default_nettype wire

### verif/pwm_map_checker.sv
module pwm_map_checker
  import pbpm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 echo_valid,
  input  wire logic                 echo_stall,
  input  wire logic [ECHO_W-1:0]    echo_us,
  input  wire logic                 result_valid,
  input  wire logic                 result_stall,
  input  wire logic [DIST_W-1:0]    distance_cm,
  input  wire logic [ZONE_W-1:0]    zone,
  input  wire logic                 suspend_buzzer,
  input  wire logic                 resume_buzzer,
  input  wire logic                 load_pwm,
  input  wire logic [PERIOD_W-1:0]  pwm_period,
  input  wire logic [DUTY_W-1:0]    duty_q16,
  input  wire logic                 config_error,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CIDX_W-1:0]    cfg_index,
  input  wire logic [CDATA_W-1:0]   cfg_data,
  output int                        fail_count,
  output int                        outstanding,
  output int                        n_near,
  output int                        n_band,
  output int                        n_far,
  output int                        n_load,
  output int                        n_sat,
  output int                        n_cerr
);

  typedef struct packed {
    logic signed [DIST_W-1:0] dist_cm;
    logic [ZONE_W-1:0]        zone;
    logic                     suspend;
    logic                     resume;
    logic                     load;
    logic [PERIOD_W-1:0]      period;
    logic [DUTY_W-1:0]        duty;
    logic                     cfg_err;
  } buzz_cmd_t;

  logic [THR_W-1:0]  high_cm;
  logic [THR_W-1:0]  med_cm;
  logic [FREQ_W-1:0] freq_hz;
  logic [ECHO_W-1:0] corr_us;
  logic              buzz_en;
  int                last_band_cm;
  int                errors;
  buzz_cmd_t         cmds_due[$];

  function automatic buzz_cmd_t map_echo(input logic [ECHO_W-1:0] echo);
    int        ev;
    int        cv;
    int        d;
    int        hi;
    int        md;
    int        r;
    int        a;
    longint    den;
    longint    per;
    longint    dut;
    buzz_cmd_t c;
    ev = echo;
    cv = corr_us;
    d = (ev - cv) / 58;
    hi = high_cm;
    md = med_cm;
    c = '0;
    c.zone = ZONE_NEAR;
    c.dist_cm = d[DIST_W-1:0];
    c.cfg_err = (hi == md);
    if (hi <= d && d <= md) begin
      c.zone = ZONE_BAND;
      if (buzz_en) begin
        c.resume = 1'b1;
        if (!c.cfg_err && d != last_band_cm) begin
          r = md - hi;
          a = d - hi;
          den = longint'(freq_hz) * (2 * r - a);
          dut = (longint'(65536) * (95 * r - 90 * a)) / (100 * r);
          if (den == 0) begin
            per = longint'(PERIOD_MAX);
          end else begin
            per = (longint'(PERIOD_SCALE) * r) / den;
          end
          if (per > longint'(PERIOD_MAX)) begin
            per = longint'(PERIOD_MAX);
          end
          c.load = 1'b1;
          c.period = per[PERIOD_W-1:0];
          c.duty = dut[DUTY_W-1:0];
        end
        last_band_cm = d;
      end
    end else if (d > md) begin
      c.zone = ZONE_FAR;
      c.suspend = 1'b1;
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    buzz_cmd_t want;
    if (rst) begin
      high_cm = HIGH_RESET;
      med_cm = MED_RESET;
      freq_hz = FREQ_RESET;
      corr_us = '0;
      buzz_en = 1'b1;
      last_band_cm = 0;
      cmds_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (cmds_due.size() == 0) begin
          $error("result item with nothing outstanding");
          errors++;
        end else begin
          want = cmds_due.pop_front();
          check_field("distance_cm", want.dist_cm, $signed(distance_cm));
          check_field("zone", want.zone, zone);
          check_field("suspend_buzzer", want.suspend, suspend_buzzer);
          check_field("resume_buzzer", want.resume, resume_buzzer);
          check_field("load_pwm", want.load, load_pwm);
          check_field("pwm_period", want.period, pwm_period);
          check_field("duty_q16", want.duty, duty_q16);
          check_field("config_error", want.cfg_err, config_error);
          case (want.zone)
            ZONE_BAND: n_band++;
            ZONE_FAR:  n_far++;
            default:   n_near++;
          endcase
          if (want.load) n_load++;
          if (want.load && want.period == PERIOD_MAX) n_sat++;
          if (want.cfg_err) n_cerr++;
        end
      end
      if (echo_valid && !echo_stall) begin
        cmds_due.push_back(map_echo(echo_us));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HIGH_RISK: high_cm = cfg_data[THR_W-1:0];
          REG_MED_RISK:  med_cm = cfg_data[THR_W-1:0];
          REG_BASE_FREQ: freq_hz = cfg_data[FREQ_W-1:0];
          REG_ECHO_CORR: corr_us = cfg_data[ECHO_W-1:0];
          REG_BUZZ_EN:   buzz_en = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding <= cmds_due.size();
    fail_count <= errors;
  end

endmodule

### verif/testbench.sv
module testbench;
  import pbpm_pkg::*;

  localparam logic [CIDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 80;

  typedef enum {RX_OPEN, RX_COIN, RX_CLOGGED, RX_EVERY_THIRD} rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      echo_valid = 1'b0;
  logic                      echo_stall;
  logic [ECHO_W-1:0]         echo_us = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic signed [DIST_W-1:0]  distance_cm;
  logic [ZONE_W-1:0]         zone;
  logic                      suspend_buzzer;
  logic                      resume_buzzer;
  logic                      load_pwm;
  logic [PERIOD_W-1:0]       pwm_period;
  logic [DUTY_W-1:0]         duty_q16;
  logic                      config_error;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CIDX_W-1:0]         cfg_index = '0;
  logic [CDATA_W-1:0]        cfg_data = '0;

  int fail_count;
  int outstanding;
  int n_near;
  int n_band;
  int n_far;
  int n_load;
  int n_sat;
  int n_cerr;

  int       cur_hi;
  int       cur_md;
  int       cur_corr;
  int       last_target;
  int       items_sent;
  int       phases;
  int       burst_left;
  bit       hold_off_req;
  int       hold_left;
  int       mode_left;
  int       rx_tick;
  rx_mode_t rx_mode;

  always #2 clk = ~clk;

  proximity_buzzer_pwm_mapper_core u_top (.*);

  pwm_map_checker u_chk (.*);

  always @(posedge clk) begin
    if (hold_off_req) begin
      hold_left = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:    result_stall <= 1'b0;
        RX_COIN:    result_stall <= 1'($urandom_range(0, 1));
        RX_CLOGGED: result_stall <= ($urandom_range(0, 3) != 0);
        default:    result_stall <= (rx_tick % 3 == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int value, input int width);
    logic [CDATA_W-1:0] noise;
    logic [CDATA_W-1:0] keep;
    noise = CDATA_W'($urandom);
    keep = CDATA_W'((1 << width) - 1);
    cfg_index <= idx;
    cfg_data <= (noise & ~keep) | (CDATA_W'(value) & keep);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int hi, input int md, input int f, input int corr,
                                input int en);
    write_reg(REG_HIGH_RISK, hi, THR_W);
    write_reg(REG_MED_RISK, md, THR_W);
    write_reg(REG_BASE_FREQ, f, FREQ_W);
    write_reg(REG_ECHO_CORR, corr, ECHO_W);
    write_reg(REG_BUZZ_EN, en, 1);
    cur_hi = hi;
    cur_md = md;
    cur_corr = corr;
    phases++;
  endtask

  task automatic send_echo(input int value);
    echo_us <= ECHO_W'(value);
    echo_valid <= 1'b1;
    do @(posedge clk); while (echo_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 5);
      echo_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12))
        @(posedge clk);
    end
  endtask

  // hold the sender until every result item is back
  task automatic drain();
    echo_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int aim(input int target_cm);
    longint v;
    v = longint'(cur_corr) + longint'(target_cm) * 58 + $urandom_range(0, 57);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return int'(v);
  endfunction

  function automatic int pick_echo();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return aim(last_target);
    if (roll < 60) begin
      last_target = $urandom_range(cur_hi, cur_md);
      return aim(last_target);
    end
    if (roll < 75) begin
      case ($urandom_range(0, 3))
        0:       last_target = cur_hi - 1;
        1:       last_target = cur_hi;
        2:       last_target = cur_md;
        default: last_target = cur_md + 1;
      endcase
      return aim(last_target);
    end
    if (roll < 92) return $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 65535;
      2:       return cur_corr;
      default: return aim(-1);
    endcase
  endfunction

  task automatic random_settings();
    int hi;
    int md;
    int f;
    int corr;
    int roll;
    roll = $urandom_range(0, 7);
    hi = $urandom_range(0, 60);
    md = hi + $urandom_range(1, 60);
    if (roll == 0) begin
      md = hi;
    end else if (roll == 1) begin
      md = $urandom_range(0, 40);
      hi = md + $urandom_range(1, 40);
    end else if (roll == 2) begin
      hi = $urandom_range(0, 511);
      md = $urandom_range(hi, 511);
    end
    case ($urandom_range(0, 5))
      0:       f = 0;
      1:       f = (1 << FREQ_W) - 1;
      2:       f = 1;
      default: f = $urandom_range(1, 20000);
    endcase
    corr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
    apply_settings(hi, md, f, corr, ($urandom_range(0, 6) != 0));
  endtask

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // band starting at zero: first hit at the stored reset distance loads nothing
    apply_settings(0, 15, 350, 0, 1);
    send_echo(10);
    send_echo(65535);
    send_echo(5 * 58);
    send_echo(5 * 58);
    send_echo(15 * 58 + 57);
    send_echo(16 * 58);
    drain();

    // correction larger than the echo: negative distance, truncation toward zero
    apply_settings(5, 15, 350, 1000, 1);
    send_echo(0);
    send_echo(941);
    send_echo(943);
    send_echo(1000 + 7 * 58);
    drain();

    apply_settings(20, 20, 350, 0, 1);
    send_echo(20 * 58);
    send_echo(21 * 58);
    send_echo(0);
    drain();

    apply_settings(30, 10, 350, 0, 1);
    send_echo(20 * 58);
    send_echo(5 * 58);
    drain();

    apply_settings(10, 12, 0, 0, 1);
    send_echo(10 * 58);
    send_echo(11 * 58);
    send_echo(12 * 58);
    drain();

    // disabled buzzer leaves the stored distance alone
    apply_settings(10, 12, 350, 0, 0);
    send_echo(11 * 58);
    drain();
    apply_settings(10, 12, 350, 0, 1);
    send_echo(12 * 58);
    send_echo(11 * 58);
    drain();

    apply_settings(0, 511, (1 << FREQ_W) - 1, 65535, 1);
    write_reg(REG_SPARE_LO, $urandom, CDATA_W);
    write_reg(REG_SPARE_HI, $urandom, CDATA_W);
    send_echo(65535);
    send_echo(0);
    drain();
    apply_settings(0, 511, 1, 0, 1);
    send_echo(511 * 58 + 57);
    send_echo(58);
    send_echo(65535);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_settings();
      last_target = cur_hi;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == 20) hold_off_req = 1'b1;
        if (ph == 5 && i == 40) drain();
        send_echo(pick_echo());
      end
      drain();
    end

    repeat (80) @(posedge clk);
    $display("Covered %0d echo items over %0d register settings: %0d near, %0d in band, %0d beyond.",
             items_sent, phases, n_near, n_band, n_far);
    $display("PWM loads %0d (%0d saturated), %0d with equal thresholds, one long result hold-off.",
             n_load, n_sat, n_cerr);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/pbpm_pkg.sv
design/proximity_buzzer_pwm_mapper_core.sv
verif/pwm_map_checker.sv
verif/testbench.sv
